### sv/tmte_pkg.sv
package tmte_pkg;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 34;
   localparam int SQ_RAD_W  = 68;
   localparam int SQ_ROOT_W = 34;

   localparam logic CSR_MAX_ACCEL       = 1'b0;
   localparam logic CSR_SAMPLE_INTERVAL = 1'b1;

   localparam logic [16:0] MAX_ACCEL_RESET       = 17'd3000;
   localparam logic [15:0] SAMPLE_INTERVAL_RESET = 16'd10;

   typedef struct packed {
      logic [31:0]        line;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic [15:0]        feed;
   } item_type;

   typedef struct packed {
      logic [16:0] accel;
      logic [15:0] interval;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                start;
      logic [SQ_RAD_W-1:0] rad;
   } sqrt_req_type;

   typedef struct packed {
      logic [31:0] line;
      logic [31:0] free_us;
      logic [31:0] limited_us;
      logic        sampled;
      logic        slow;
      logic        turn;
      logic        stop;
      logic [47:0] total_free;
      logic [47:0] total_limited;
      logic [47:0] total_distance;
   } rsp_type;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      logic [32:0] r;
      r = v[32] ? 33'(-v) : 33'(v);
      return r;
   endfunction

   function automatic logic [16:0] mag18(input logic signed [17:0] v);
      logic [17:0] r;
      r = v[17] ? 18'(-v) : 18'(v);
      return r[16:0];
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [55:0] b);
      logic [56:0] s;
      s = {9'b0, a} + {1'b0, b};
      return (|s[56:48]) ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [55:0] v);
      return (|v[55:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

### sv/trapezoid_move_time_estimator.sv
// Front end takes one word per cycle if the queue has room; words that make no segment
// leave no result. In the back end a segment runs six to eight 64-step divisions and one
// or two 34-step square roots on one shared divider and one root unit.
// Throughput is one segment per back-end pass; a queue of FIFO_DEPTH segments decouples them.
// Synchronous active-high reset clears position, direction, speed, counter and totals,
// and sets max_accel to 3000 and sample_interval to 10.
module trapezoid_move_time_estimator import tmte_pkg::*; #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64], feed_mm_per_min[111:96]
   input  logic [111:0] req_tdata,
   // is_motion[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // line_index[31:0], free_time_us[63:32], limited_time_us[95:64], sampled[96],
   // slow_segment[97], direction_turn[98], accel_bound_stop[99], total_free_us[147:100],
   // total_limited_us[195:148], total_distance_um[243:196], zero[247:244]
   output logic [247:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [16:0]  csr_data
);

   logic [16:0] accel_ff, accel_in;
   logic [15:0] interval_ff, interval_in;
   cfg_type     cfg;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   item_type    push_item, pop_item;
   rsp_type     rsp_word;

   always_comb begin
      csr_ready   = 1'b1;
      accel_in    = accel_ff;
      interval_in = interval_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_ACCEL:       accel_in    = csr_data;
            CSR_SAMPLE_INTERVAL: interval_in = csr_data[15:0];
            default:             accel_in    = accel_ff;
         endcase
      end
      cfg.accel    = (accel_ff == '0) ? 17'd1 : accel_ff;
      cfg.interval = (interval_ff == '0) ? 16'd1 : interval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff    <= MAX_ACCEL_RESET;
         interval_ff <= SAMPLE_INTERVAL_RESET;
      end else begin
         accel_ff    <= accel_in;
         interval_ff <= interval_in;
      end
   end

   tmte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pos_x      (req_tdata[31:0]),
      .pos_y      (req_tdata[63:32]),
      .pos_z      (req_tdata[95:64]),
      .feed       (req_tdata[111:96]),
      .is_motion  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   tmte_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tmte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {4'b0000,
                       rsp_word.total_distance,
                       rsp_word.total_limited,
                       rsp_word.total_free,
                       rsp_word.stop,
                       rsp_word.turn,
                       rsp_word.slow,
                       rsp_word.sampled,
                       rsp_word.limited_us,
                       rsp_word.free_us,
                       rsp_word.line};

endmodule

### sv/tmte_front.sv
module tmte_front import tmte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] pos_x,
   input  logic [31:0] pos_y,
   input  logic [31:0] pos_z,
   input  logic [15:0] feed,
   input  logic        is_motion,
   output logic        push_valid,
   input  logic        push_ready,
   output item_type    push_item
);

   logic [31:0] last_x_ff, last_x_in;
   logic [31:0] last_y_ff, last_y_in;
   logic [31:0] last_z_ff, last_z_in;
   logic [31:0] count_ff, count_in;
   logic signed [32:0] dx, dy, dz;
   logic        accept;
   logic        small_x, small_y, small_z, zero_x, zero_y, zero_z;
   logic [1:0]  nonzero;

   always_comb begin
      dx = $signed({pos_x[31], pos_x}) - $signed({last_x_ff[31], last_x_ff});
      dy = $signed({pos_y[31], pos_y}) - $signed({last_y_ff[31], last_y_ff});
      dz = $signed({pos_z[31], pos_z}) - $signed({last_z_ff[31], last_z_ff});
      zero_x  = (dx == 33'sd0);
      zero_y  = (dy == 33'sd0);
      zero_z  = (dz == 33'sd0);
      small_x = zero_x || (dx == 33'sd1) || (dx == -33'sd1);
      small_y = zero_y || (dy == 33'sd1) || (dy == -33'sd1);
      small_z = zero_z || (dz == 33'sd1) || (dz == -33'sd1);
      nonzero = 2'({1'b0, !zero_x}) + 2'({1'b0, !zero_y}) + 2'({1'b0, !zero_z});

      req_tready = push_ready;
      accept     = req_tvalid && req_tready;
      push_valid = accept && is_motion && (feed != 16'd0)
                   && !(small_x && small_y && small_z && (nonzero <= 2'd1));
      push_item.line = count_ff;
      push_item.dx   = dx;
      push_item.dy   = dy;
      push_item.dz   = dz;
      push_item.feed = feed;

      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      last_z_in = last_z_ff;
      count_in  = count_ff;
      if (accept) begin
         count_in = count_ff + 32'd1;
         if (is_motion) begin
            last_x_in = pos_x;
            last_y_in = pos_y;
            last_z_in = pos_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
         last_z_ff <= '0;
         count_ff  <= '0;
      end else begin
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         last_z_ff <= last_z_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/tmte_fifo.sv
module tmte_fifo import tmte_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int AW = $clog2(DEPTH);

   item_type       mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in;
   logic [AW-1:0]  rd_ff, rd_in;
   logic [AW:0]    count_ff, count_in;
   logic           push, pop;

   always_comb begin
      push_ready = (count_ff != (AW+1)'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_item   = mem_ff[rd_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_in      = wr_ff;
      rd_in      = rd_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/tmte_div.sv
module tmte_div import tmte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          req,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo,
   output logic [DIV_DEN_W-1:0] rem
);

   logic [DIV_NUM_W-1:0] work_ff, work_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [6:0]           count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   always_comb begin
      trial    = {rem_ff, work_ff[DIV_NUM_W-1]};
      ge       = (trial >= {1'b0, den_ff});
      work_in  = work_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         work_in  = req.num;
         rem_in   = '0;
         den_in   = req.den;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         work_in  = {work_ff[DIV_NUM_W-2:0], ge};
         count_in = count_ff + 7'd1;
         if (count_ff == 7'(DIV_NUM_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = work_ff;
   assign rem  = rem_ff;

endmodule

### sv/tmte_sqrt.sv
module tmte_sqrt import tmte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  sqrt_req_type       req,
   output logic               done,
   output logic [SQ_ROOT_W:0] root
);

   logic [SQ_RAD_W-1:0]  rad_ff, rad_in;
   logic [SQ_ROOT_W+1:0] rem_ff, rem_in;
   logic [SQ_ROOT_W-1:0] root_ff, root_in;
   logic [5:0]           count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SQ_ROOT_W+3:0] t, trial;
   logic                 ge;

   always_comb begin
      t        = {rem_ff, rad_ff[SQ_RAD_W-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      ge       = (t >= trial);
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rad_in   = req.rad;
         rem_in   = '0;
         root_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? (SQ_ROOT_W+2)'(t - trial) : t[SQ_ROOT_W+1:0];
         root_in  = {root_ff[SQ_ROOT_W-2:0], ge};
         rad_in   = {rad_ff[SQ_RAD_W-3:0], 2'b00};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'(SQ_ROOT_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      root = {1'b0, root_ff} + (SQ_ROOT_W+1)'(rem_ff > {2'b00, root_ff});
   end

   always_ff @(posedge clock) begin
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;

endmodule

### sv/tmte_back.sv
module tmte_back import tmte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  item_type pop_item,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output rsp_type  rsp_word
);

   localparam logic [5:0] S_IDLE    = 6'd0;
   localparam logic [5:0] S_MX      = 6'd1;
   localparam logic [5:0] S_MY      = 6'd2;
   localparam logic [5:0] S_MZ      = 6'd3;
   localparam logic [5:0] S_SUMZ    = 6'd4;
   localparam logic [5:0] S_SQRT    = 6'd5;
   localparam logic [5:0] S_SQRT_W  = 6'd6;
   localparam logic [5:0] S_FREE_M  = 6'd7;
   localparam logic [5:0] S_FREE_D  = 6'd8;
   localparam logic [5:0] S_FREE_W  = 6'd9;
   localparam logic [5:0] S_UNIT_D  = 6'd10;
   localparam logic [5:0] S_UNIT_W  = 6'd11;
   localparam logic [5:0] S_DOT_M   = 6'd12;
   localparam logic [5:0] S_DOT_A   = 6'd13;
   localparam logic [5:0] S_V_M     = 6'd14;
   localparam logic [5:0] S_V_D     = 6'd15;
   localparam logic [5:0] S_V_W     = 6'd16;
   localparam logic [5:0] S_UD_M    = 6'd17;
   localparam logic [5:0] S_DD_M    = 6'd18;
   localparam logic [5:0] S_NUM     = 6'd19;
   localparam logic [5:0] S_DEN_M   = 6'd20;
   localparam logic [5:0] S_DDEN_M  = 6'd21;
   localparam logic [5:0] S_CMP     = 6'd22;
   localparam logic [5:0] S_STOP_M  = 6'd23;
   localparam logic [5:0] S_STOP_D  = 6'd24;
   localparam logic [5:0] S_STOP_W  = 6'd25;
   localparam logic [5:0] S_STOP_SW = 6'd26;
   localparam logic [5:0] S_ACC_M   = 6'd27;
   localparam logic [5:0] S_ACC_D   = 6'd28;
   localparam logic [5:0] S_ACC_W   = 6'd29;
   localparam logic [5:0] S_CRU_D   = 6'd30;
   localparam logic [5:0] S_CRU_W   = 6'd31;
   localparam logic [5:0] S_CRUS_D  = 6'd32;
   localparam logic [5:0] S_CRUS_W  = 6'd33;
   localparam logic [5:0] S_SMP_D   = 6'd34;
   localparam logic [5:0] S_SMP_W   = 6'd35;
   localparam logic [5:0] S_FIN     = 6'd36;
   localparam logic [5:0] S_OUT     = 6'd37;

   logic [5:0]  state_ff, state_in;
   item_type    itm_ff, itm_in;
   logic [67:0] prod_ff, prod_in;
   logic [33:0] mul_a, mul_b;
   logic [67:0] sum_sq_ff, sum_sq_in;
   logic [33:0] dist_ff, dist_in;
   logic [49:0] free_ff, free_in;
   logic [1:0]  axis_ff, axis_in;
   logic signed [17:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [35:0] dot_ff, dot_in;
   logic        turn_ff, turn_in;
   logic [20:0] v_ff, v_in;
   logic [20:0] u_ff, u_in;
   logic [20:0] delta_ff, delta_in;
   logic [41:0] ud_ff, ud_in;
   logic [43:0] num_ff, num_in;
   logic [27:0] den_ff, den_in;
   logic [61:0] dd_ff, dd_in;
   logic        stop_ff, stop_in;
   logic [31:0] acc_ff, acc_in;
   logic [53:0] cruise_ff, cruise_in;
   logic [55:0] limited_ff, limited_in;
   logic        sampled_ff, sampled_in;
   logic        slow_ff, slow_in;

   logic signed [17:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in, dir_z_ff, dir_z_in;
   logic        have_dir_ff, have_dir_in;
   logic [20:0] speed_ff, speed_in;
   logic [47:0] tot_free_ff, tot_free_in;
   logic [47:0] tot_lim_ff, tot_lim_in;
   logic [47:0] tot_dist_ff, tot_dist_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   div_req_type  div_req;
   logic         div_done;
   logic [63:0]  div_quo;
   logic [33:0]  div_rem;
   sqrt_req_type sq_req;
   logic         sq_done;
   logic [34:0]  sq_root;

   logic signed [32:0] d_sel;
   logic signed [17:0] n_sel, dir_sel;
   logic [16:0] q_clamp;
   logic signed [17:0] n_new;
   logic [20:0] v_new;
   logic [35:0] dot_term;
   logic [43:0] cruise_nm;
   logic [59:0] lim_x10;
   logic [59:0] free_x11;

   tmte_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   tmte_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_comb begin
      case (axis_ff)
         2'd0: begin
            d_sel   = itm_ff.dx;
            n_sel   = nx_ff;
            dir_sel = dir_x_ff;
         end
         2'd1: begin
            d_sel   = itm_ff.dy;
            n_sel   = ny_ff;
            dir_sel = dir_y_ff;
         end
         default: begin
            d_sel   = itm_ff.dz;
            n_sel   = nz_ff;
            dir_sel = dir_z_ff;
         end
      endcase
      q_clamp   = (div_quo > 64'd65536) ? 17'd65536 : div_quo[16:0];
      n_new     = d_sel[32] ? 18'(-$signed({1'b0, q_clamp})) : $signed({1'b0, q_clamp});
      v_new     = prod_ff[46:26];
      dot_term  = {3'b000, prod_ff[32:0]};
      cruise_nm = div_quo[43:0];
      lim_x10   = {1'b0, limited_ff, 3'b000} + {3'b000, limited_ff, 1'b0};
      free_x11  = {7'b0, free_ff, 3'b000} + {9'b0, free_ff, 1'b0} + {10'b0, free_ff};
   end

   always_comb begin
      state_in    = state_ff;
      itm_in      = itm_ff;
      sum_sq_in   = sum_sq_ff;
      dist_in     = dist_ff;
      free_in     = free_ff;
      axis_in     = axis_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      nz_in       = nz_ff;
      dot_in      = dot_ff;
      turn_in     = turn_ff;
      v_in        = v_ff;
      u_in        = u_ff;
      delta_in    = delta_ff;
      ud_in       = ud_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      dd_in       = dd_ff;
      stop_in     = stop_ff;
      acc_in      = acc_ff;
      cruise_in   = cruise_ff;
      limited_in  = limited_ff;
      sampled_in  = sampled_ff;
      slow_in     = slow_ff;
      dir_x_in    = dir_x_ff;
      dir_y_in    = dir_y_ff;
      dir_z_in    = dir_z_ff;
      have_dir_in = have_dir_ff;
      speed_in    = speed_ff;
      tot_free_in = tot_free_ff;
      tot_lim_in  = tot_lim_ff;
      tot_dist_in = tot_dist_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop_ready   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;
      sq_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               itm_in   = pop_item;
               axis_in  = 2'd0;
               dot_in   = '0;
               state_in = S_MX;
            end
         end
         S_MX: begin
            mul_a    = {1'b0, mag33(itm_ff.dx)};
            mul_b    = {1'b0, mag33(itm_ff.dx)};
            state_in = S_MY;
         end
         S_MY: begin
            sum_sq_in = prod_ff;
            mul_a     = {1'b0, mag33(itm_ff.dy)};
            mul_b     = {1'b0, mag33(itm_ff.dy)};
            state_in  = S_MZ;
         end
         S_MZ: begin
            sum_sq_in = sum_sq_ff + prod_ff;
            mul_a     = {1'b0, mag33(itm_ff.dz)};
            mul_b     = {1'b0, mag33(itm_ff.dz)};
            state_in  = S_SUMZ;
         end
         S_SUMZ: begin
            sum_sq_in = sum_sq_ff + prod_ff;
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            sq_req.start = 1'b1;
            sq_req.rad   = sum_sq_ff;
            state_in     = S_SQRT_W;
         end
         S_SQRT_W: begin
            if (sq_done) begin
               dist_in  = sq_root[33:0];
               state_in = S_FREE_M;
            end
         end
         S_FREE_M: begin
            mul_a    = dist_ff;
            mul_b    = 34'd60000;
            state_in = S_FREE_D;
         end
         S_FREE_D: begin
            div_req.start = 1'b1;
            div_req.num   = {14'b0, prod_ff[49:0]} + {49'b0, itm_ff.feed[15:1]};
            div_req.den   = {18'b0, itm_ff.feed};
            state_in      = S_FREE_W;
         end
         S_FREE_W: begin
            if (div_done) begin
               free_in  = div_quo[49:0];
               axis_in  = 2'd0;
               state_in = S_UNIT_D;
            end
         end
         S_UNIT_D: begin
            div_req.start = 1'b1;
            div_req.num   = {15'b0, mag33(d_sel), 16'b0} + {31'b0, dist_ff[33:1]};
            div_req.den   = dist_ff;
            state_in      = S_UNIT_W;
         end
         S_UNIT_W: begin
            if (div_done) begin
               case (axis_ff)
                  2'd0:    nx_in = n_new;
                  2'd1:    ny_in = n_new;
                  default: nz_in = n_new;
               endcase
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  state_in = S_DOT_M;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_UNIT_D;
               end
            end
         end
         S_DOT_M: begin
            mul_a    = {17'b0, mag18(dir_sel)};
            mul_b    = {17'b0, mag18(n_sel)};
            state_in = S_DOT_A;
         end
         S_DOT_A: begin
            dot_in = (dir_sel[17] ^ n_sel[17]) ? dot_ff - $signed(dot_term)
                                                : dot_ff + $signed(dot_term);
            if (axis_ff == 2'd2) begin
               state_in = S_V_M;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_DOT_M;
            end
         end
         S_V_M: begin
            turn_in  = have_dir_ff && (dot_ff < 36'sd2147483648);
            u_in     = (have_dir_ff && (dot_ff < 36'sd2147483648)) ? 21'd0 : speed_ff;
            mul_a    = {18'b0, itm_ff.feed};
            mul_b    = 34'd100;
            state_in = S_V_D;
         end
         S_V_D: begin
            // divide by six through the reciprocal 2^26 / 6, rounded up
            mul_a    = {11'b0, prod_ff[22:0] + 23'd3};
            mul_b    = 34'd11184811;
            state_in = S_V_W;
         end
         S_V_W: begin
            v_in     = v_new;
            delta_in = (v_new > u_ff) ? v_new - u_ff : u_ff - v_new;
            state_in = S_UD_M;
         end
         S_UD_M: begin
            mul_a    = {13'b0, u_ff};
            mul_b    = {13'b0, delta_ff};
            state_in = S_DD_M;
         end
         S_DD_M: begin
            ud_in    = prod_ff[41:0];
            mul_a    = {13'b0, delta_ff};
            mul_b    = {13'b0, delta_ff};
            state_in = S_NUM;
         end
         S_NUM: begin
            num_in   = {1'b0, ud_ff, 1'b0} + {2'b0, prod_ff[41:0]};
            state_in = S_DEN_M;
         end
         S_DEN_M: begin
            mul_a    = {17'b0, cfg.accel};
            mul_b    = 34'd2000;
            state_in = S_DDEN_M;
         end
         S_DDEN_M: begin
            den_in   = prod_ff[27:0];
            mul_a    = dist_ff;
            mul_b    = {6'b0, prod_ff[27:0]};
            state_in = S_CMP;
         end
         S_CMP: begin
            dd_in    = prod_ff[61:0];
            stop_in  = ({18'b0, num_ff} >= prod_ff[61:0]);
            state_in = ({18'b0, num_ff} >= prod_ff[61:0]) ? S_STOP_M : S_ACC_M;
         end
         S_STOP_M: begin
            mul_a    = dist_ff;
            mul_b    = 34'd2000000000;
            state_in = S_STOP_D;
         end
         S_STOP_D: begin
            div_req.start = 1'b1;
            div_req.num   = prod_ff[63:0];
            div_req.den   = {17'b0, cfg.accel};
            state_in      = S_STOP_W;
         end
         S_STOP_W: begin
            if (div_done) begin
               sq_req.start = 1'b1;
               sq_req.rad   = {4'b0, div_quo};
               state_in     = S_STOP_SW;
            end
         end
         S_STOP_SW: begin
            if (sq_done) begin
               limited_in = {21'b0, sq_root};
               state_in   = S_SMP_D;
            end
         end
         S_ACC_M: begin
            mul_a    = {13'b0, delta_ff};
            mul_b    = 34'd1000;
            state_in = S_ACC_D;
         end
         S_ACC_D: begin
            div_req.start = 1'b1;
            div_req.num   = {33'b0, prod_ff[30:0]} + {48'b0, cfg.accel[16:1]};
            div_req.den   = {17'b0, cfg.accel};
            state_in      = S_ACC_W;
         end
         S_ACC_W: begin
            if (div_done) begin
               acc_in   = div_quo[31:0];
               state_in = S_CRU_D;
            end
         end
         S_CRU_D: begin
            div_req.start = 1'b1;
            div_req.num   = {2'b0, dd_ff - {18'b0, num_ff}};
            div_req.den   = {16'b0, cfg.accel, 1'b0};
            state_in      = S_CRU_W;
         end
         S_CRU_W: begin
            if (div_done) begin
               cruise_in = {cruise_nm, 10'b0} - {6'b0, cruise_nm, 4'b0}
                           - {7'b0, cruise_nm, 3'b0};
               state_in  = S_CRUS_D;
            end
         end
         S_CRUS_D: begin
            div_req.start = 1'b1;
            div_req.num   = {10'b0, cruise_ff} + {44'b0, v_ff[20:1]};
            div_req.den   = {13'b0, v_ff};
            state_in      = S_CRUS_W;
         end
         S_CRUS_W: begin
            if (div_done) begin
               limited_in = {23'b0, acc_ff, 1'b0} + {6'b0, div_quo[49:0]};
               state_in   = S_SMP_D;
            end
         end
         S_SMP_D: begin
            div_req.start = 1'b1;
            div_req.num   = {32'b0, itm_ff.line};
            div_req.den   = {18'b0, cfg.interval};
            state_in      = S_SMP_W;
         end
         S_SMP_W: begin
            if (div_done) begin
               sampled_in = (div_rem == '0);
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            tot_free_in = sat_add48(tot_free_ff, {6'b0, free_ff});
            tot_lim_in  = sat_add48(tot_lim_ff, limited_ff);
            tot_dist_in = sat_add48(tot_dist_ff, {22'b0, dist_ff});
            slow_in     = (lim_x10 > free_x11);
            dir_x_in    = nx_ff;
            dir_y_in    = ny_ff;
            dir_z_in    = nz_ff;
            have_dir_in = 1'b1;
            speed_in    = v_ff;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.line           = itm_ff.line;
               rsp_in.free_us        = sat32({6'b0, free_ff});
               rsp_in.limited_us     = sat32(limited_ff);
               rsp_in.sampled        = sampled_ff;
               rsp_in.slow           = slow_ff;
               rsp_in.turn           = turn_ff;
               rsp_in.stop           = stop_ff;
               rsp_in.total_free     = tot_free_ff;
               rsp_in.total_limited  = tot_lim_ff;
               rsp_in.total_distance = tot_dist_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      itm_ff     <= itm_in;
      prod_ff    <= prod_in;
      sum_sq_ff  <= sum_sq_in;
      dist_ff    <= dist_in;
      free_ff    <= free_in;
      axis_ff    <= axis_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      nz_ff      <= nz_in;
      dot_ff     <= dot_in;
      turn_ff    <= turn_in;
      v_ff       <= v_in;
      u_ff       <= u_in;
      delta_ff   <= delta_in;
      ud_ff      <= ud_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      dd_ff      <= dd_in;
      stop_ff    <= stop_in;
      acc_ff     <= acc_in;
      cruise_ff  <= cruise_in;
      limited_ff <= limited_in;
      sampled_ff <= sampled_in;
      slow_ff    <= slow_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         dir_x_ff     <= '0;
         dir_y_ff     <= '0;
         dir_z_ff     <= '0;
         have_dir_ff  <= 1'b0;
         speed_ff     <= '0;
         tot_free_ff  <= '0;
         tot_lim_ff   <= '0;
         tot_dist_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_x_ff     <= dir_x_in;
         dir_y_ff     <= dir_y_in;
         dir_z_ff     <= dir_z_in;
         have_dir_ff  <= have_dir_in;
         speed_ff     <= speed_in;
         tot_free_ff  <= tot_free_in;
         tot_lim_ff   <= tot_lim_in;
         tot_dist_ff  <= tot_dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule
